// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the thermal erosion RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tte_pkg.sv =====
// Shared types and constants for the thermal erosion block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tte_pkg;

    // Default largest grid side.
    localparam int MAX_SIDE_DEF = 256;

    // Register and field widths.
    localparam int GRID_W = 9;
    localparam int RATE_W = 16;
    localparam int PASS_W = 10;
    localparam int HGT_W  = 32;

    // Register reset values.
    localparam logic [GRID_W-1:0] GRID_RST = 9'd256;
    localparam logic [RATE_W-1:0] RATE_RST = 16'd0;
    localparam logic [PASS_W-1:0] PASS_RST = 10'd10;

    // Largest move fraction, one half in Q0.16.
    localparam logic [RATE_W-1:0] HALF_Q16 = 16'h8000;

    // Command kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_ERODE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_GRID_SIDE = 2'd0;
    localparam logic [1:0] REG_RATE      = 2'd1;
    localparam logic [1:0] REG_PASSES    = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]              kind;
        logic [15:0]             cell_index;
        logic signed [HGT_W-1:0] height_in;
    } t_in;

    // Result item.
    typedef struct packed {
        logic signed [HGT_W-1:0] height_out;
        logic                    erosion_done;
    } t_out;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_PASS_CHK,
        ST_CP_RD,
        ST_CP_WR,
        ST_CELL,
        ST_NB_RD,
        ST_NB_CAP,
        ST_EVAL,
        ST_SRC_RD,
        ST_SRC_WR,
        ST_DST_RD,
        ST_DST_WR,
        ST_NEXT_CELL,
        ST_BK_RD,
        ST_BK_WR,
        ST_PASS_END,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hw_host;
        logic hr_host;
        logic out_read;
        logic out_done;
        logic pass_clr;
        logic pass_inc;
        logic cnt_clr;
        logic cnt_inc;
        logic cp_wr_s;
        logic cp_wr_h;
        logic cell_init;
        logic cell_next;
        logic nb_clr;
        logic nb_rd;
        logic nb_cap;
        logic mul;
        logic src_rd;
        logic src_wr;
        logic dst_rd;
        logic dst_wr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
        logic pass_done;
        logic cells_zero;
        logic no_interior;
        logic cnt_last;
        logic nb_last;
        logic best_pos;
        logic cell_last;
    } t_stat;

    // Saturate a 33-bit signed sum to the signed 32-bit range.
    function automatic logic [HGT_W-1:0] sat32(input logic [HGT_W:0] v);
        logic [HGT_W-1:0] r;
        if (v[HGT_W] != v[HGT_W-1]) begin
            r = v[HGT_W] ? {1'b1, {(HGT_W-1){1'b0}}} : {1'b0, {(HGT_W-1){1'b1}}};
        end else begin
            r = v[HGT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/terrain_thermal_erosion.sv =====
// Top level of the thermal erosion block: configuration registers, controller
// and datapath. Depends on tte_pkg, tte_ctrl, tte_datapath and assert_macros.svh.
//
// Usage: the input channel (i_in_valid, o_in_ready, i_in_data) carries commands:
// write a cell height, run the erosion passes, or read a cell height. The output
// channel (o_out_valid, i_out_ready, o_out_data) returns one result for a read
// and one acknowledge (erosion_done set, height zero) for an erosion command.
// Writes are taken back to back while the block is idle, also while a result
// waits. A read's height passes through the registered read port of the
// height memory and then the output register. An erosion command occupies
// the block for pass_count passes. Each pass copies the map to scratch, visits
// each interior cell to search its neighbors and move material where the
// steepest drop is positive, then copies scratch back. The acknowledge is
// registered after the last pass, through the pass check and done states.
// When the receiver stalls, the result stays in the output register, and reads
// or erosion commands are held off until it is taken. Synchronous reset returns
// the controller to idle, clears the result valid flag and restores the
// configuration registers; the memories are not cleared. Configuration is to be
// written over the APB port while the block is idle, which is not enforced.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module terrain_thermal_erosion #(
    parameter int MAX_SIDE = tte_pkg::MAX_SIDE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tte_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tte_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [tte_pkg::GRID_W-1:0] r_grid_side;
    logic [tte_pkg::RATE_W-1:0] r_erosion_rate;
    logic [tte_pkg::PASS_W-1:0] r_pass_count;
    logic                       cfg_wr;

    tte_pkg::t_cmd  cmd;
    tte_pkg::t_stat stat;

    // Configuration writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side    <= tte_pkg::GRID_RST;
            r_erosion_rate <= tte_pkg::RATE_RST;
            r_pass_count   <= tte_pkg::PASS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                tte_pkg::REG_GRID_SIDE: r_grid_side    <= pwdata[tte_pkg::GRID_W-1:0];
                tte_pkg::REG_RATE:      r_erosion_rate <= pwdata[tte_pkg::RATE_W-1:0];
                tte_pkg::REG_PASSES:    r_pass_count   <= pwdata[tte_pkg::PASS_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            tte_pkg::REG_GRID_SIDE: prdata = 32'(r_grid_side);
            tte_pkg::REG_RATE:      prdata = 32'(r_erosion_rate);
            tte_pkg::REG_PASSES:    prdata = 32'(r_pass_count);
            default:                prdata = '0;
        endcase
    end

    tte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tte_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_in_data      (i_in_data),
        .i_grid_side    (r_grid_side),
        .i_erosion_rate (r_erosion_rate),
        .i_pass_count   (r_pass_count),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

    // Checks on command sequencing and results.
    logic acc_read;
    logic acc_busy;

    assign acc_read = i_rst_n && i_in_valid && o_in_ready &&
                      (i_in_data.kind == tte_pkg::KIND_READ);
    assign acc_busy = i_rst_n && i_in_valid && o_in_ready &&
                      ((i_in_data.kind == tte_pkg::KIND_READ) ||
                       (i_in_data.kind == tte_pkg::KIND_ERODE));

    `TTE_ASSERT_NEXT(a_busy_after_cmd, acc_busy, !o_in_ready, "block took a command while busy")
    `TTE_ASSERT_SAME(a_done_zero, o_out_valid && o_out_data.erosion_done,
        o_out_data.height_out == '0, "erosion acknowledge carries a nonzero height")
    `TTE_ASSERT_SAME(a_read_result, $past(acc_read, 2) && $past(i_rst_n, 1),
        o_out_valid && !o_out_data.erosion_done, "read result missing two cycles after transfer")

endmodule

// ===== rtl/core/tte_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/tte_datapath.sv =====
// Datapath of the thermal erosion block: height and scratch memories, cell
// and neighbor counters, slope search, move multiplier and result register.
// Depends on tte_pkg and tte_ram.
`timescale 1ns / 1ps

module tte_datapath #(
    parameter int MAX_SIDE = tte_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tte_pkg::t_cmd               i_cmd,
    output tte_pkg::t_stat              o_stat,
    input  tte_pkg::t_in                i_in_data,
    input  logic [tte_pkg::GRID_W-1:0]  i_grid_side,
    input  logic [tte_pkg::RATE_W-1:0]  i_erosion_rate,
    input  logic [tte_pkg::PASS_W-1:0]  i_pass_count,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output tte_pkg::t_out               o_out_data
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = 2 * SW;
    localparam int GW    = (SW > tte_pkg::GRID_W) ? SW : tte_pkg::GRID_W;
    localparam int IW    = (AW > 16) ? AW : 16;
    localparam int CW    = (IW > NW) ? IW : NW;
    localparam int HW    = tte_pkg::HGT_W;
    localparam int RW    = tte_pkg::RATE_W;
    localparam int MW    = HW + RW;

    localparam logic [AW-1:0] ONE_A = AW'(1);
    localparam logic [SW-1:0] ONE_S = SW'(1);
    localparam logic [SW-1:0] TWO_S = SW'(2);

    // Side in use and the cell count.
    logic [GW-1:0] side_w;
    logic [SW-1:0] side;
    logic [NW-1:0] cells;
    logic [AW-1:0] side_a;
    logic [IW-1:0] idx_w;
    logic [AW-1:0] host_addr;
    logic          in_range;

    assign side_w    = GW'(i_grid_side);
    assign side      = (side_w > GW'(MAX_SIDE)) ? SW'(MAX_SIDE) : side_w[SW-1:0];
    assign cells     = NW'(side) * NW'(side);
    assign side_a    = AW'(side);
    assign idx_w     = IW'(i_in_data.cell_index);
    assign host_addr = idx_w[AW-1:0];
    assign in_range  = CW'(idx_w) < CW'(cells);

    // Registers.
    logic [AW-1:0]          r_cnt;
    logic [SW-1:0]          r_x, r_y;
    logic [AW-1:0]          r_here;
    logic [3:0]             r_k;
    logic [HW-1:0]          r_h;
    logic signed [HW:0]     r_best;
    logic [AW-1:0]          r_target;
    logic [HW-1:0]          r_amt;
    logic [tte_pkg::PASS_W-1:0] r_pass;
    logic                   r_rd_ok;
    logic                   r_out_valid;
    tte_pkg::t_out          r_out_data;

    // Memory ports.
    logic          h_we, s_we;
    logic [AW-1:0] h_waddr, h_raddr, s_waddr, s_raddr;
    logic [HW-1:0] h_wdata, h_rdata, s_wdata, s_rdata;

    // Neighbor address for the current search step, raster order.
    logic [AW-1:0] nb_addr;
    always_comb begin
        unique case (r_k)
            4'd1:    nb_addr = r_here - side_a - ONE_A;
            4'd2:    nb_addr = r_here - side_a;
            4'd3:    nb_addr = r_here - side_a + ONE_A;
            4'd4:    nb_addr = r_here - ONE_A;
            4'd5:    nb_addr = r_here + ONE_A;
            4'd6:    nb_addr = r_here + side_a - ONE_A;
            4'd7:    nb_addr = r_here + side_a;
            4'd8:    nb_addr = r_here + side_a + ONE_A;
            default: nb_addr = r_here;
        endcase
    end

    // Drop toward the neighbor and the move amount.
    logic signed [HW:0] drop;
    logic [RW-1:0]      frac;
    logic [MW-1:0]      prod;
    logic [HW:0]        src_sum, dst_sum;

    assign drop    = $signed({r_h[HW-1], r_h}) - $signed({h_rdata[HW-1], h_rdata});
    assign frac    = (i_erosion_rate > tte_pkg::HALF_Q16) ? tte_pkg::HALF_Q16 : i_erosion_rate;
    assign prod    = MW'(r_best[HW-1:0]) * MW'(frac);
    assign src_sum = {s_rdata[HW-1], s_rdata} - {1'b0, r_amt};
    assign dst_sum = {s_rdata[HW-1], s_rdata} + {1'b0, r_amt};

    // Height memory port selection.
    assign h_we    = (i_cmd.hw_host && in_range) || i_cmd.cp_wr_h;
    assign h_waddr = i_cmd.hw_host ? host_addr : r_cnt;
    assign h_wdata = i_cmd.hw_host ? i_in_data.height_in : s_rdata;
    assign h_raddr = i_cmd.hr_host ? host_addr : (i_cmd.nb_rd ? nb_addr : r_cnt);

    // Scratch memory port selection.
    assign s_we    = i_cmd.cp_wr_s || i_cmd.src_wr || i_cmd.dst_wr;
    assign s_waddr = i_cmd.cp_wr_s ? r_cnt : (i_cmd.src_wr ? r_here : r_target);
    assign s_wdata = i_cmd.cp_wr_s ? h_rdata :
                     (i_cmd.src_wr ? tte_pkg::sat32(src_sum) : tte_pkg::sat32(dst_sum));
    assign s_raddr = i_cmd.src_rd ? r_here : (i_cmd.dst_rd ? r_target : r_cnt);

    tte_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    tte_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Copy counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + ONE_A;
        end
    end

    // Interior cell walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_init) begin
            r_x    <= ONE_S;
            r_y    <= ONE_S;
            r_here <= side_a + ONE_A;
        end else if (i_cmd.cell_next) begin
            if (r_x == side - TWO_S) begin
                r_x    <= ONE_S;
                r_y    <= r_y + ONE_S;
                r_here <= r_here + AW'(3);
            end else begin
                r_x    <= r_x + ONE_S;
                r_here <= r_here + ONE_A;
            end
        end
    end

    // Steepest descent search; the first strict maximum wins.
    always_ff @(posedge i_clk) begin
        if (i_cmd.nb_clr) begin
            r_k      <= 4'd0;
            r_best   <= '0;
            r_target <= r_here;
        end else if (i_cmd.nb_cap) begin
            r_k <= r_k + 4'd1;
            if (r_k == 4'd0) begin
                r_h <= h_rdata;
            end else if (drop > r_best) begin
                r_best   <= drop;
                r_target <= nb_addr;
            end
        end
    end

    // Move amount, floored.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_amt <= prod[MW-1:RW];
        end
    end

    // Pass counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
        end else if (i_cmd.pass_clr) begin
            r_pass <= '0;
        end else if (i_cmd.pass_inc) begin
            r_pass <= r_pass + 1'b1;
        end
    end

    // Range flag of a host read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hr_host) begin
            r_rd_ok <= in_range;
        end
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_read || i_cmd.out_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_read) begin
            r_out_data.height_out   <= r_rd_ok ? h_rdata : '0;
            r_out_data.erosion_done <= 1'b0;
        end else if (i_cmd.out_done) begin
            r_out_data.height_out   <= '0;
            r_out_data.erosion_done <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status toward the controller.
    assign o_stat.out_valid   = r_out_valid;
    assign o_stat.pass_done   = (r_pass == i_pass_count);
    assign o_stat.cells_zero  = (side == '0);
    assign o_stat.no_interior = (side < SW'(3));
    assign o_stat.cnt_last    = (NW'(r_cnt) == cells - NW'(1));
    assign o_stat.nb_last     = (r_k == 4'd8);
    assign o_stat.best_pos    = !r_best[HW] && (r_best != '0);
    assign o_stat.cell_last   = (r_x == side - TWO_S) && (r_y == side - TWO_S);

endmodule

// ===== rtl/core/tte_ctrl.sv =====
// Controller state machine of the thermal erosion block.
// Depends on tte_pkg; drives the datapath through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module tte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_kind,
    output logic           o_in_ready,
    input  tte_pkg::t_stat i_stat,
    output tte_pkg::t_cmd  o_cmd
);

    tte_pkg::t_state r_state, n_state;
    logic            needs_out;
    logic            acc;

    // Reads and erosion commands need the result register free.
    assign needs_out  = (i_in_kind == tte_pkg::KIND_READ) ||
                        (i_in_kind == tte_pkg::KIND_ERODE);
    assign o_in_ready = (r_state == tte_pkg::ST_IDLE) && !(needs_out && i_stat.out_valid);
    assign acc        = i_in_valid && o_in_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tte_pkg::ST_IDLE: begin
                if (acc && i_in_kind == tte_pkg::KIND_READ) begin
                    n_state = tte_pkg::ST_READ_WAIT;
                end else if (acc && i_in_kind == tte_pkg::KIND_ERODE) begin
                    n_state = tte_pkg::ST_PASS_CHK;
                end
            end
            tte_pkg::ST_READ_WAIT: n_state = tte_pkg::ST_IDLE;
            tte_pkg::ST_PASS_CHK: begin
                priority if (i_stat.pass_done) begin
                    n_state = tte_pkg::ST_DONE;
                end else if (i_stat.cells_zero) begin
                    n_state = tte_pkg::ST_PASS_END;
                end else begin
                    n_state = tte_pkg::ST_CP_RD;
                end
            end
            tte_pkg::ST_CP_RD: n_state = tte_pkg::ST_CP_WR;
            tte_pkg::ST_CP_WR: begin
                if (!i_stat.cnt_last) begin
                    n_state = tte_pkg::ST_CP_RD;
                end else if (i_stat.no_interior) begin
                    n_state = tte_pkg::ST_BK_RD;
                end else begin
                    n_state = tte_pkg::ST_CELL;
                end
            end
            tte_pkg::ST_CELL:   n_state = tte_pkg::ST_NB_RD;
            tte_pkg::ST_NB_RD:  n_state = tte_pkg::ST_NB_CAP;
            tte_pkg::ST_NB_CAP: begin
                n_state = i_stat.nb_last ? tte_pkg::ST_EVAL : tte_pkg::ST_NB_RD;
            end
            tte_pkg::ST_EVAL: begin
                n_state = i_stat.best_pos ? tte_pkg::ST_SRC_RD : tte_pkg::ST_NEXT_CELL;
            end
            tte_pkg::ST_SRC_RD: n_state = tte_pkg::ST_SRC_WR;
            tte_pkg::ST_SRC_WR: n_state = tte_pkg::ST_DST_RD;
            tte_pkg::ST_DST_RD: n_state = tte_pkg::ST_DST_WR;
            tte_pkg::ST_DST_WR: n_state = tte_pkg::ST_NEXT_CELL;
            tte_pkg::ST_NEXT_CELL: begin
                n_state = i_stat.cell_last ? tte_pkg::ST_BK_RD : tte_pkg::ST_CELL;
            end
            tte_pkg::ST_BK_RD: n_state = tte_pkg::ST_BK_WR;
            tte_pkg::ST_BK_WR: begin
                n_state = i_stat.cnt_last ? tte_pkg::ST_PASS_END : tte_pkg::ST_BK_RD;
            end
            tte_pkg::ST_PASS_END: n_state = tte_pkg::ST_PASS_CHK;
            tte_pkg::ST_DONE:     n_state = tte_pkg::ST_IDLE;
            default:              n_state = tte_pkg::ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tte_pkg::ST_IDLE: begin
                o_cmd.hw_host  = acc && (i_in_kind == tte_pkg::KIND_WRITE);
                o_cmd.hr_host  = acc && (i_in_kind == tte_pkg::KIND_READ);
                o_cmd.pass_clr = acc && (i_in_kind == tte_pkg::KIND_ERODE);
            end
            tte_pkg::ST_READ_WAIT: o_cmd.out_read = 1'b1;
            tte_pkg::ST_PASS_CHK:  o_cmd.cnt_clr  = 1'b1;
            tte_pkg::ST_CP_RD:     o_cmd.cnt_inc  = 1'b0;
            tte_pkg::ST_CP_WR: begin
                o_cmd.cp_wr_s   = 1'b1;
                o_cmd.cnt_inc   = 1'b1;
                o_cmd.cnt_clr   = i_stat.cnt_last;
                o_cmd.cell_init = i_stat.cnt_last;
            end
            tte_pkg::ST_CELL:      o_cmd.nb_clr = 1'b1;
            tte_pkg::ST_NB_RD:     o_cmd.nb_rd  = 1'b1;
            tte_pkg::ST_NB_CAP:    o_cmd.nb_cap = 1'b1;
            tte_pkg::ST_EVAL:      o_cmd.mul    = 1'b1;
            tte_pkg::ST_SRC_RD:    o_cmd.src_rd = 1'b1;
            tte_pkg::ST_SRC_WR:    o_cmd.src_wr = 1'b1;
            tte_pkg::ST_DST_RD:    o_cmd.dst_rd = 1'b1;
            tte_pkg::ST_DST_WR:    o_cmd.dst_wr = 1'b1;
            tte_pkg::ST_NEXT_CELL: o_cmd.cell_next = !i_stat.cell_last;
            tte_pkg::ST_BK_RD:     o_cmd.cnt_inc = 1'b0;
            tte_pkg::ST_BK_WR: begin
                o_cmd.cp_wr_h = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            tte_pkg::ST_PASS_END: begin
                o_cmd.pass_inc = 1'b1;
                o_cmd.cnt_clr  = 1'b1;
            end
            tte_pkg::ST_DONE: begin
                o_cmd.out_done = 1'b1;
                o_cmd.pass_clr = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
